// ===== rtl/core/rct_pkg.sv =====
// rct_pkg: shared types and constants for the reply correlation table
// no dependencies; used by the interfaces, the cell and the top level

package rct_pkg;

    // table depth, one cell per entry
    localparam int ENTRIES = 16;

    localparam int CORR_W = 32;
    localparam int PORT_W = 16;
    localparam int WORD_W = 64;

    // operation codes
    typedef enum logic {
        FUNC_STORE = 1'b0,
        FUNC_TAKE  = 1'b1
    } t_func;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // request token that walks the cell row
    typedef struct packed {
        logic              live;
        logic              done;
        t_func             func;
        logic [CORR_W-1:0] corr;
        logic              family;
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] addr_hi;
        logic [WORD_W-1:0] addr_lo;
        logic [WORD_W-1:0] cookie;
    } t_tok;

endpackage

// ===== rtl/core/rct_ifs.sv =====
// rct_ifs: request and response channel interfaces (valid/ready plus payload)
// depends on rct_pkg for field widths

interface rct_req_if import rct_pkg::*;;
    logic              valid;
    logic              ready;
    logic              func;
    logic [CORR_W-1:0] corr;
    logic              family;
    logic [PORT_W-1:0] port;
    logic [WORD_W-1:0] addr_hi;
    logic [WORD_W-1:0] addr_lo;
    logic [WORD_W-1:0] cookie;
    logic              cookie_given;

    modport source (
        output valid, func, corr, family, port, addr_hi, addr_lo, cookie, cookie_given,
        input  ready
    );
    modport sink (
        input  valid, func, corr, family, port, addr_hi, addr_lo, cookie, cookie_given,
        output ready
    );
endinterface

interface rct_rsp_if import rct_pkg::*;;
    logic              valid;
    logic              ready;
    logic              status;
    logic              out_family;
    logic [PORT_W-1:0] out_port;
    logic [WORD_W-1:0] out_addr_hi;
    logic [WORD_W-1:0] out_addr_lo;
    logic [WORD_W-1:0] out_cookie;

    modport source (
        output valid, status, out_family, out_port, out_addr_hi, out_addr_lo, out_cookie,
        input  ready
    );
    modport sink (
        input  valid, status, out_family, out_port, out_addr_hi, out_addr_lo, out_cookie,
        output ready
    );
endinterface

// ===== rtl/core/reply_correlation_table.sv =====
// reply_correlation_table_top: row of table cells with request entry and result register
// depends on rct_pkg, rct_ifs (rct_req_if, rct_rsp_if) and rct_cell
//
// the request token walks the cell row one cell per cycle unless a full result register
//   stalls the row; a new request enters once the result is registered
// reset: clears every entry valid bit, the in-flight token, the busy flag and the result
//   valid flag; entry contents and the result payload are not cleared

module reply_correlation_table_top import rct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rct_req_if.sink   i_req,
    rct_rsp_if.source o_rsp
);

    t_tok              w_tok [ENTRIES+1];
    logic [ENTRIES-1:0] w_live;
    logic              w_in_acc;
    logic              w_out_load;
    logic              w_adv;
    logic              w_take_hit;
    t_tok              w_end;

    logic              r_busy;
    logic              r_out_valid;
    logic              r_status;
    logic              r_family;
    logic [PORT_W-1:0] r_port;
    logic [WORD_W-1:0] r_addr_hi;
    logic [WORD_W-1:0] r_addr_lo;
    logic [WORD_W-1:0] r_cookie;

    // request entry: one beat in flight at a time
    assign i_req.ready = !r_busy;
    assign w_in_acc    = i_req.valid && i_req.ready;

    always_comb begin
        w_tok[0].live    = w_in_acc;
        w_tok[0].done    = 1'b0;
        w_tok[0].func    = t_func'(i_req.func);
        w_tok[0].corr    = i_req.corr;
        w_tok[0].family  = i_req.family;
        w_tok[0].port    = i_req.port;
        w_tok[0].addr_hi = i_req.addr_hi;
        w_tok[0].addr_lo = i_req.addr_lo;
        w_tok[0].cookie  = i_req.cookie_given ? i_req.cookie : '0;
    end

    // cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // row end and stall control
    always_comb begin
        w_end = w_tok[ENTRIES];
        for (int k = 0; k < ENTRIES; k++) begin
            w_live[k] = w_tok[k+1].live;
        end
    end

    assign w_out_load = w_end.live && (!r_out_valid || o_rsp.ready);
    assign w_adv      = !w_end.live || w_out_load;
    assign w_take_hit = w_end.done && (w_end.func == FUNC_TAKE);

    // busy flag and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status  <= w_end.done ? STATUS_OK : STATUS_FAIL;
            r_family  <= w_take_hit ? w_end.family  : 1'b0;
            r_port    <= w_take_hit ? w_end.port    : '0;
            r_addr_hi <= w_take_hit ? w_end.addr_hi : '0;
            r_addr_lo <= w_take_hit ? w_end.addr_lo : '0;
            r_cookie  <= w_take_hit ? w_end.cookie  : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_family  = r_family;
    assign o_rsp.out_port    = r_port;
    assign o_rsp.out_addr_hi = r_addr_hi;
    assign o_rsp.out_addr_lo = r_addr_lo;
    assign o_rsp.out_cookie  = r_cookie;

    // at most one token walks the row
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one token in the cell row");

    // an idle block has an empty row
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_live == '0))
        else $error("token in the row while not busy");

    // a blocked token stays at the row end
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.live && !w_adv) |=> (w_end.live && $stable(w_end.corr)))
        else $error("token lost while the result register was full");

    // an accepted beat marks the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_busy && !w_out_load))
        else $error("busy flag not set after an accepted beat");

endmodule

// ===== rtl/core/rct_cell.sv =====
// rct_cell: one table entry plus one stage of the request token row
// depends on rct_pkg for the token type and operation codes

module rct_cell import rct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_tok i_tok,
    output t_tok o_tok
);

    // entry storage
    logic              r_valid;
    logic              n_valid;
    logic [CORR_W-1:0] r_id;
    logic              r_family;
    logic [PORT_W-1:0] r_port;
    logic [WORD_W-1:0] r_addr_hi;
    logic [WORD_W-1:0] r_addr_lo;
    logic [WORD_W-1:0] r_cookie;

    t_tok r_tok;
    t_tok n_tok;
    logic w_open;
    logic w_hit_store;
    logic w_hit_take;

    // a still-unserved token claims this entry if it fits
    always_comb begin
        w_open      = i_adv && i_tok.live && !i_tok.done;
        w_hit_store = w_open && (i_tok.func == FUNC_STORE) && !r_valid;
        w_hit_take  = w_open && (i_tok.func == FUNC_TAKE) && r_valid && (r_id == i_tok.corr);
        n_tok       = i_tok;
        n_valid     = r_valid;
        if (w_hit_store) begin
            n_tok.done = 1'b1;
            n_valid    = 1'b1;
        end
        if (w_hit_take) begin
            n_tok.done    = 1'b1;
            n_tok.family  = r_family;
            n_tok.port    = r_port;
            n_tok.addr_hi = r_addr_hi;
            n_tok.addr_lo = r_addr_lo;
            n_tok.cookie  = r_cookie;
            n_valid       = 1'b0;
        end
    end

    // token stage and valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_adv) begin
                r_tok <= n_tok;
            end
            r_valid <= n_valid;
        end
    end

    // entry payload write on store
    always_ff @(posedge i_clk) begin
        if (w_hit_store) begin
            r_id      <= i_tok.corr;
            r_family  <= i_tok.family;
            r_port    <= i_tok.port;
            r_addr_hi <= i_tok.addr_hi;
            r_addr_lo <= i_tok.addr_lo;
            r_cookie  <= i_tok.cookie;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== dv/reply_correlation_table_top_tb.sv =====
// testbench for reply_correlation_table_top: store and take requests checked against a
// cycle-free table predictor; depends on rct_pkg and rct_ifs (rct_req_if, rct_rsp_if)
`timescale 1ns / 100ps

module reply_correlation_table_top_tb;
    import rct_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int CHUNK_OPS    = 99;
    localparam int CHUNK_COUNT  = 19;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_func             func;
        logic [CORR_W-1:0] corr;
        logic              family;
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] addr_hi;
        logic [WORD_W-1:0] addr_lo;
        logic [WORD_W-1:0] cookie;
        logic              cookie_given;
    } t_table_op;

    typedef struct packed {
        logic              status;
        logic              family;
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] addr_hi;
        logic [WORD_W-1:0] addr_lo;
        logic [WORD_W-1:0] cookie;
    } t_reply_dest;

    logic i_clk;
    logic i_rst_n;

    rct_req_if req_if ();
    rct_rsp_if rsp_if ();

    reply_correlation_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // predicted table contents
    bit                slot_valid [ENTRIES] = '{default: 1'b0};
    logic [CORR_W-1:0] slot_corr  [ENTRIES];
    logic              slot_family[ENTRIES];
    logic [PORT_W-1:0] slot_port  [ENTRIES];
    logic [WORD_W-1:0] slot_hi    [ENTRIES];
    logic [WORD_W-1:0] slot_lo    [ENTRIES];
    logic [WORD_W-1:0] slot_cookie[ENTRIES];

    t_table_op   op_backlog[$];
    t_reply_dest pending_replies[$];
    t_table_op   op_on_bus;

    // ids the stimulus believes are live in the table, in store order
    logic [CORR_W-1:0] live_ids[$];
    logic [CORR_W-1:0] hot_ids[4];

    bit steady = 1'b0;
    int mismatch_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int idle_cycles = 0;

    // apply one operation to the predicted table and return its reply
    function automatic t_reply_dest apply_table_op(t_table_op op);
        t_reply_dest res;
        bit          hit;
        res = '0;
        res.status = STATUS_FAIL;
        hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && op.func == FUNC_STORE && !slot_valid[i]) begin
                hit = 1'b1;
                slot_valid[i]  = 1'b1;
                slot_corr[i]   = op.corr;
                slot_family[i] = op.family;
                slot_port[i]   = op.port;
                slot_hi[i]     = op.addr_hi;
                slot_lo[i]     = op.addr_lo;
                slot_cookie[i] = op.cookie_given ? op.cookie : '0;
                res.status     = STATUS_OK;
            end else if (!hit && op.func == FUNC_TAKE && slot_valid[i]
                         && slot_corr[i] == op.corr) begin
                hit = 1'b1;
                slot_valid[i] = 1'b0;
                res.status    = STATUS_OK;
                res.family    = slot_family[i];
                res.port      = slot_port[i];
                res.addr_hi   = slot_hi[i];
                res.addr_lo   = slot_lo[i];
                res.cookie    = slot_cookie[i];
            end
        end
        return res;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // queue an operation and keep the live id list in step with the table
    task automatic queue_op(input t_table_op op);
        int idx;
        idx = -1;
        if (op.func == FUNC_STORE) begin
            if (live_ids.size() < ENTRIES)
                live_ids.push_back(op.corr);
        end else begin
            for (int i = 0; i < live_ids.size(); i++)
                if (idx < 0 && live_ids[i] == op.corr)
                    idx = i;
            if (idx >= 0)
                live_ids.delete(idx);
        end
        op_backlog.push_back(op);
    endtask

    task automatic queue_store(input logic [CORR_W-1:0] corr, input logic family,
                               input logic [PORT_W-1:0] port,
                               input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo,
                               input logic [WORD_W-1:0] cookie, input logic given);
        t_table_op op;
        op = '{FUNC_STORE, corr, family, port, hi, lo, cookie, given};
        queue_op(op);
    endtask

    task automatic queue_take(input logic [CORR_W-1:0] corr);
        t_table_op op;
        op = '{FUNC_TAKE, corr, 1'($urandom()), 16'($urandom()), rand_word(), rand_word(),
               rand_word(), 1'($urandom())};
        queue_op(op);
    endtask

    // random operation: takes mostly hit a live id, stores often reuse hot ids
    task automatic queue_random_op(input int store_pct);
        logic [CORR_W-1:0] id;
        int                r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < store_pct) begin
            if (r < 50)
                id = hot_ids[$urandom_range(0, 3)];
            else
                id = $urandom();
            queue_store(id, 1'($urandom()), 16'($urandom()), rand_word(), rand_word(),
                        rand_word(), 1'($urandom()));
        end else begin
            if (live_ids.size() > 0 && r < 85)
                id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else if (r < 92)
                id = hot_ids[$urandom_range(0, 3)];
            else
                id = $urandom();
            queue_take(id);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (op_backlog.size() != 0 || req_if.valid || pending_replies.size() != 0);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // request driver: holds the beat until accepted, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid        <= 1'b0;
            req_if.func         <= FUNC_STORE;
            req_if.corr         <= '0;
            req_if.family       <= 1'b0;
            req_if.port         <= '0;
            req_if.addr_hi      <= '0;
            req_if.addr_lo      <= '0;
            req_if.cookie       <= '0;
            req_if.cookie_given <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                pending_replies.push_back(apply_table_op(op_on_bus));
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    op_on_bus = op_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.func         <= op_on_bus.func;
                    req_if.corr         <= op_on_bus.corr;
                    req_if.family       <= op_on_bus.family;
                    req_if.port         <= op_on_bus.port;
                    req_if.addr_hi      <= op_on_bus.addr_hi;
                    req_if.addr_lo      <= op_on_bus.addr_lo;
                    req_if.cookie       <= op_on_bus.cookie;
                    req_if.cookie_given <= op_on_bus.cookie_given;
                    send_gap = pick_gap();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor: compares each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_reply_dest want;
        t_reply_dest got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.status, rsp_if.out_family, rsp_if.out_port,
                        rsp_if.out_addr_hi, rsp_if.out_addr_lo, rsp_if.out_cookie};
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("reply beat with nothing outstanding: %h", got);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.family !== want.family
                        || got.port !== want.port || got.addr_hi !== want.addr_hi
                        || got.addr_lo !== want.addr_lo || got.cookie !== want.cookie) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("reply mismatch at %0t", $realtime);
                            $display("  expected st=%b fam=%b port=%h hi=%h lo=%h ck=%h",
                                     want.status, want.family, want.port, want.addr_hi,
                                     want.addr_lo, want.cookie);
                            $display("  actual   st=%b fam=%b port=%h hi=%h lo=%h ck=%h",
                                     got.status, got.family, got.port, got.addr_hi,
                                     got.addr_lo, got.cookie);
                        end
                    end
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, field extremes, zero cookie, duplicate ids
        queue_take('0);
        queue_store('1, 1'b1, '1, '1, '1, '1, 1'b1);
        queue_store('0, 1'b0, '0, '0, '0, '1, 1'b0);
        queue_store('0, 1'b1, 16'h1234, rand_word(), rand_word(), rand_word(), 1'b1);
        queue_take('0);
        queue_take('1);
        queue_take('0);
        queue_take('0);
        // fill every entry, then one store too many
        for (int i = 0; i <= ENTRIES; i++)
            queue_store(CORR_W'(i), 1'($urandom()), 16'($urandom()), rand_word(),
                        rand_word(), rand_word(), 1'($urandom()));
        wait_drained();

        // random phases, each with a store share of 15, 50 or 85 percent picked at random
        for (int c = 0; c < CHUNK_COUNT; c++) begin
            int store_pct;
            case ($urandom_range(0, 2))
                0: store_pct = 15;
                1: store_pct = 50;
                default: store_pct = 85;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            for (int h = 0; h < 4; h++)
                hot_ids[h] = ($urandom_range(0, 1) == 0) ? CORR_W'($urandom_range(0, 3))
                                                         : CORR_W'($urandom());
            for (int n = 0; n < CHUNK_OPS; n++)
                queue_random_op(store_pct);
            wait_drained();
        end

        repeat (ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
